// File: rtl/core/articulation_point_finder_top_assert.svh
// Assertion macros shared by the checker.
`ifndef ARTICULATION_POINT_FINDER_TOP_ASSERT_SVH
`define ARTICULATION_POINT_FINDER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define APF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define APF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/core/apf_pkg.sv
package apf_pkg;

  localparam int MaxNodes = 64;

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_COMPUTE  = 1'b1;

  localparam logic [0:0] REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic       command;
    logic [5:0] node_a;
    logic [5:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [5:0] cut_node;
    logic       found;
    logic [6:0] cut_total;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_ROOT,
    ST_READ_TOP,
    ST_READ_ROW,
    ST_STEP,
    ST_POP,
    ST_FIN_ROOT,
    ST_COUNT,
    ST_EMIT,
    ST_CLEAR_ADJ
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_edge;
    logic clear_flags;
    logic scan_root;
    logic start_root;
    logic read_top;
    logic read_row;
    logic step;
    logic pop;
    logic fin_root;
    logic count;
    logic emit_scan;
    logic emit_push;
    logic clear_adj;
    logic reset_idx;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic idx_done;
    logic root_unvisited;
    logic stack_empty;
    logic cursor_done;
    logic emit_hit;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/apf_ctrl.sv
module apf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           in_command,
  input  apf_pkg::stat_t stat,
  output apf_pkg::cmd_t  cmd,
  output logic           busy
);

  apf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != apf_pkg::ST_IDLE);
    unique case (state)
      apf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_command == apf_pkg::CMD_COMPUTE) begin
            cmd.reset_idx = 1'b1;
            cmd.clear_flags = 1'b1;
            state_next = apf_pkg::ST_SCAN_ROOT;
          end else begin
            cmd.load_edge = 1'b1;
          end
        end
      end
      apf_pkg::ST_SCAN_ROOT: begin
        if (stat.idx_done) begin
          cmd.reset_idx = 1'b1;
          state_next = apf_pkg::ST_COUNT;
        end else if (stat.root_unvisited) begin
          cmd.start_root = 1'b1;
          state_next = apf_pkg::ST_READ_TOP;
        end else begin
          cmd.scan_root = 1'b1;
        end
      end
      apf_pkg::ST_READ_TOP: begin
        if (stat.stack_empty) begin
          state_next = apf_pkg::ST_FIN_ROOT;
        end else begin
          cmd.read_top = 1'b1;
          state_next = apf_pkg::ST_READ_ROW;
        end
      end
      apf_pkg::ST_READ_ROW: begin
        cmd.read_row = 1'b1;
        state_next = apf_pkg::ST_STEP;
      end
      apf_pkg::ST_STEP: begin
        if (stat.cursor_done) begin
          state_next = apf_pkg::ST_POP;
        end else begin
          cmd.step = 1'b1;
          state_next = apf_pkg::ST_READ_TOP;
        end
      end
      apf_pkg::ST_POP: begin
        cmd.pop = 1'b1;
        state_next = apf_pkg::ST_READ_TOP;
      end
      apf_pkg::ST_FIN_ROOT: begin
        cmd.fin_root = 1'b1;
        cmd.scan_root = 1'b1;
        state_next = apf_pkg::ST_SCAN_ROOT;
      end
      apf_pkg::ST_COUNT: begin
        if (stat.idx_done) begin
          cmd.reset_idx = 1'b1;
          state_next = apf_pkg::ST_EMIT;
        end else begin
          cmd.count = 1'b1;
        end
      end
      apf_pkg::ST_EMIT: begin
        if (stat.idx_done) begin
          cmd.reset_idx = 1'b1;
          state_next = apf_pkg::ST_CLEAR_ADJ;
        end else if (stat.emit_hit) begin
          if (stat.out_free) begin
            cmd.emit_push = 1'b1;
            cmd.emit_scan = 1'b1;
          end
        end else begin
          cmd.emit_scan = 1'b1;
        end
      end
      apf_pkg::ST_CLEAR_ADJ: begin
        cmd.clear_adj = 1'b1;
        if (stat.idx_done) begin
          state_next = apf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = apf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/apf_datapath.sv
module apf_datapath (
  input  logic               clk,
  input  logic               rst,
  input  apf_pkg::in_item_t  in_item,
  input  logic [6:0]         node_count,
  input  apf_pkg::cmd_t      cmd,
  output apf_pkg::stat_t     stat,
  output logic               out_valid,
  input  logic               out_stall,
  output apf_pkg::out_item_t out_item
);

  localparam int MaxNodes = apf_pkg::MaxNodes;
  localparam int IW = $clog2(MaxNodes);
  localparam int CW = $clog2(MaxNodes + 1);

  // Adjacency matrix rows; a row reads as empty until its valid bit is set.
  logic [MaxNodes-1:0] adj [MaxNodes];
  logic [MaxNodes-1:0] adj_rst_ok;
  logic [MaxNodes-1:0] visited;
  logic [MaxNodes-1:0] cut_flags;
  logic [IW-1:0] node_depth [MaxNodes];
  logic [IW-1:0] low_depth  [MaxNodes];
  logic [IW-1:0] stk_node   [MaxNodes];
  logic [CW-1:0] stk_cursor [MaxNodes];
  logic [IW-1:0] stk_parent [MaxNodes];
  logic [CW-1:0] sp;
  logic [CW-1:0] root_children;
  logic [CW-1:0] idx;
  logic [CW-1:0] n_eff;
  logic [6:0]    total;
  logic [6:0]    emitted;
  logic [IW-1:0] root;

  // Registered top of stack and the entries read for it.
  logic [IW-1:0] t;
  logic [IW-1:0] v;
  logic [CW-1:0] c;
  logic [IW-1:0] par;
  logic [IW-1:0] p;
  logic [IW-1:0] c_i;
  logic [MaxNodes-1:0] row_v;
  logic          row_ok;
  logic [IW-1:0] dv;
  logic [IW-1:0] dc;
  logic [IW-1:0] lv;
  logic [IW-1:0] lp;
  logic [IW-1:0] t_p;

  logic [IW-1:0] ia, ib;
  logic [MaxNodes-1:0] bit_a, bit_b;
  logic edge_ok;
  logic no_cut_push;

  assign n_eff = (node_count > 7'(MaxNodes)) ? CW'(MaxNodes) : CW'(node_count);
  assign c_i = c[IW-1:0];
  assign t_p = t - 1'b1;

  assign ia = in_item.node_a;
  assign ib = in_item.node_b;
  assign bit_a = MaxNodes'(1) << ia;
  assign bit_b = MaxNodes'(1) << ib;

  always_comb begin
    stat.idx_done = (idx >= n_eff);
    stat.root_unvisited = !visited[idx[IW-1:0]];
    stat.stack_empty = (sp == '0);
    stat.cursor_done = (c >= n_eff);
    stat.emit_hit = cut_flags[idx[IW-1:0]];
    stat.out_free = !out_valid || !out_stall;
  end

  assign edge_ok = (in_item.node_a != in_item.node_b) &&
                   (32'(in_item.node_a) < MaxNodes) && (32'(in_item.node_b) < MaxNodes);

  // The single result of a run that found no cut vertex.
  assign no_cut_push = cmd.clear_adj && idx == '0 && total == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_rst_ok <= '0;
      visited <= '0;
      cut_flags <= '0;
      sp <= '0;
      root_children <= '0;
      idx <= '0;
      total <= '0;
      emitted <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_push || no_cut_push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load_edge && edge_ok) begin
        if (adj_rst_ok[ia]) adj[ia][ib] <= 1'b1;
        else adj[ia] <= bit_b;
        if (adj_rst_ok[ib]) adj[ib][ia] <= 1'b1;
        else adj[ib] <= bit_a;
        adj_rst_ok <= adj_rst_ok | bit_a | bit_b;
      end else if (cmd.clear_adj) begin
        adj_rst_ok <= '0;
      end
      if (cmd.clear_flags) begin
        visited <= '0;
        cut_flags <= '0;
        total <= '0;
        emitted <= '0;
      end
      if (cmd.reset_idx) begin
        idx <= '0;
      end
      if (cmd.scan_root) begin
        idx <= idx + 1'b1;
      end
      if (cmd.start_root) begin
        root <= idx[IW-1:0];
        visited[idx[IW-1:0]] <= 1'b1;
        node_depth[idx[IW-1:0]] <= '0;
        low_depth[idx[IW-1:0]] <= '0;
        stk_node[0] <= idx[IW-1:0];
        stk_cursor[0] <= '0;
        stk_parent[0] <= '0;
        sp <= CW'(1);
        root_children <= '0;
      end
      if (cmd.read_top) begin
        t <= IW'(sp - 1'b1);
        v <= stk_node[IW'(sp - 1'b1)];
        c <= stk_cursor[IW'(sp - 1'b1)];
        par <= stk_parent[IW'(sp - 1'b1)];
        p <= stk_node[IW'(sp - 2'd2)];
      end
      if (cmd.read_row) begin
        row_v <= adj[v];
        row_ok <= adj_rst_ok[v];
        dv <= node_depth[v];
        dc <= node_depth[c_i];
        lv <= low_depth[v];
        lp <= low_depth[p];
      end
      if (cmd.step) begin
        stk_cursor[t] <= c + 1'b1;
        if (row_ok && row_v[c_i] && !(t != '0 && c_i == par)) begin
          if (visited[c_i]) begin
            if (dc < lv) low_depth[v] <= dc;
          end else if (sp < CW'(MaxNodes)) begin
            visited[c_i] <= 1'b1;
            node_depth[c_i] <= dv + 1'b1;
            low_depth[c_i] <= dv + 1'b1;
            stk_node[sp[IW-1:0]] <= c_i;
            stk_cursor[sp[IW-1:0]] <= '0;
            stk_parent[sp[IW-1:0]] <= v;
            sp <= sp + 1'b1;
            if (t == '0) root_children <= root_children + 1'b1;
          end
        end
      end
      if (cmd.pop) begin
        sp <= sp - 1'b1;
        if (t != '0) begin
          if (lv < lp) low_depth[p] <= lv;
          // The parent sits one level above v, so its depth is dv - 1.
          if (t_p != '0 && ({1'b0, lv} + 1'b1 >= {1'b0, dv}))
            cut_flags[p] <= 1'b1;
        end
      end
      if (cmd.fin_root && root_children >= CW'(2)) begin
        cut_flags[root] <= 1'b1;
      end
      if (cmd.count) begin
        idx <= idx + 1'b1;
        if (cut_flags[idx[IW-1:0]]) total <= total + 1'b1;
      end
      if (cmd.emit_scan) begin
        idx <= idx + 1'b1;
      end
      if (cmd.emit_push) begin
        out_item.cut_node <= idx[IW-1:0];
        out_item.found <= 1'b1;
        out_item.cut_total <= total;
        out_item.last <= (emitted + 1'b1 == total);
        emitted <= emitted + 1'b1;
      end else if (no_cut_push) begin
        out_item <= '{cut_node: '0, found: 1'b0, cut_total: '0, last: 1'b1};
      end
      if (cmd.clear_adj) begin
        idx <= n_eff;
      end
    end
  end

endmodule

// File: rtl/core/articulation_point_finder_top.sv
// Channel  | Direction | Handshake       | Payload
// in       | into      | in_valid/stall  | command, node_a, node_b
// out      | out of    | out_valid/stall | cut_node, found, cut_total, last
// Edges stream in at one item per cycle while no result waits to be taken.
// A compute item runs a depth-first search with an explicit stack: each
// cursor position of a node passes READ_TOP, READ_ROW and STEP, a pop passes
// READ_TOP, READ_ROW, STEP and POP; the block then counts the flags, emits
// results, stalling while out_stall is high, and clears the matrix.
// The result register is held while out_stall is high; reset is synchronous.
// After reset the matrix reads as empty through per-row valid bits.
module articulation_point_finder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  apf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output apf_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [6:0] node_count;
  logic busy;
  logic in_fire;
  apf_pkg::cmd_t cmd;
  apf_pkg::stat_t stat;

  assign pready = 1'b1;
  // Items are taken only while the controller is idle and no result waits.
  assign in_stall = busy || out_valid;
  assign in_fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'd64;
    end else if (psel && penable && pwrite &&
                 paddr == 2'(4 * apf_pkg::REG_NODE_COUNT)) begin
      node_count <= pwdata[6:0];
    end
  end

  // Only one register; reads return it at address zero.
  assign prdata = (paddr == 2'(4 * apf_pkg::REG_NODE_COUNT)) ?
                  {25'd0, node_count} : 32'd0;

  apf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_command(in_item.command),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  apf_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .node_count(node_count),
    .cmd(cmd), .stat(stat), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

endmodule

// File: rtl/core/apf_checker.sv
`include "articulation_point_finder_top_assert.svh"
module apf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input apf_pkg::out_item_t out_item
);
  `APF_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
  `APF_ASSERT_IMP(a_nofound_last, clk, rst, out_valid && !out_item.found, out_item.last)
  `APF_ASSERT_IMP(a_busy_out, clk, rst, out_valid, in_stall)
endmodule

bind articulation_point_finder_top apf_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

// File: verif/tb_articulation_point_finder_top.sv
module tb_articulation_point_finder_top;

  // The watchdog fires after this many cycles in which neither channel moves
  // an item; it covers a full 64-node compute run plus a long receiver hold-off.
  localparam int StallLimit = 200000;
  localparam int SettleCycles = 400;

  // Scoreboard: keeps its own copy of the adjacency matrix and node count,
  // computes the cut vertices whenever a compute item is accepted, and
  // compares every result with the oldest one still waiting.
  class cut_scoreboard;
    logic [63:0] adj [64];
    int unsigned nodes;
    apf_pkg::out_item_t waiting [$];
    int errors;

    function new();
      foreach (adj[i]) adj[i] = '0;
      nodes = 64;
      errors = 0;
    endfunction

    function void find_cuts();
      int n, sp, rc, t, v, c, p, total, k;
      bit seen [64];
      bit cut [64];
      int dep [64];
      int low [64];
      int snode [64];
      int scur [65];
      int spar [64];
      apf_pkg::out_item_t r;
      n = (nodes > 64) ? 64 : nodes;
      foreach (seen[i]) begin
        seen[i] = 0;
        cut[i] = 0;
      end
      for (int root = 0; root < n; root++) begin
        if (seen[root]) continue;
        seen[root] = 1;
        dep[root] = 0;
        low[root] = 0;
        snode[0] = root;
        scur[0] = 0;
        spar[0] = 0;
        sp = 1;
        rc = 0;
        while (sp > 0) begin
          t = sp - 1;
          v = snode[t];
          c = scur[t];
          if (c < n) begin
            scur[t] = c + 1;
            if (!adj[v][c]) continue;
            if (t > 0 && c == spar[t]) continue;
            if (seen[c]) begin
              if (dep[c] < low[v]) low[v] = dep[c];
            end else if (sp < 64) begin
              seen[c] = 1;
              dep[c] = dep[v] + 1;
              low[c] = dep[c];
              snode[sp] = c;
              scur[sp] = 0;
              spar[sp] = v;
              sp++;
              if (t == 0) rc++;
            end
          end else begin
            sp--;
            if (t > 0) begin
              p = snode[t-1];
              if (low[v] < low[p]) low[p] = low[v];
              if (t - 1 > 0 && low[v] >= dep[p]) cut[p] = 1;
            end
          end
        end
        if (rc >= 2) cut[root] = 1;
      end
      total = 0;
      for (int i = 0; i < n; i++) if (cut[i]) total++;
      if (total == 0) begin
        r.cut_node = '0;
        r.found = 1'b0;
        r.cut_total = '0;
        r.last = 1'b1;
        waiting.push_back(r);
      end else begin
        k = 0;
        for (int i = 0; i < n; i++) begin
          if (!cut[i]) continue;
          k++;
          r.cut_node = 6'(i);
          r.found = 1'b1;
          r.cut_total = 7'(total);
          r.last = (k == total);
          waiting.push_back(r);
        end
      end
      foreach (adj[i]) adj[i] = '0;
    endfunction

    function void note_item(apf_pkg::in_item_t it);
      if (it.command == apf_pkg::CMD_ADD_EDGE) begin
        if (it.node_a != it.node_b) begin
          adj[it.node_a][it.node_b] = 1'b1;
          adj[it.node_b][it.node_a] = 1'b1;
        end
      end else begin
        find_cuts();
      end
    endfunction

    function void check_result(apf_pkg::out_item_t got);
      apf_pkg::out_item_t exp;
      if (waiting.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = waiting.pop_front();
      if (got.cut_node !== exp.cut_node || got.found !== exp.found ||
          got.cut_total !== exp.cut_total || got.last !== exp.last) begin
        $display("%0t: mismatch, expected %p, actual %p", $time, exp, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  apf_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  apf_pkg::out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  cut_scoreboard sb;

  // Idle rates in percent for each side; the main sequence sets them per phase.
  int send_pct;
  int recv_pct;
  // A hold-off request is a counter bump; the receiver process notices it.
  int hold_asked;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  // Number of input items accepted so far.
  int items_sent;

  articulation_point_finder_top u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Monitor and watchdog. Values read right after the edge are the ones the
  // block saw at that edge, since every input changes by nonblocking update.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_item(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= StallLimit) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Receiver: random stalls at the phase rate, or a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // Offers one item, with random idle cycles ahead of it. Valid stays high
  // after acceptance so back-to-back items need no extra assignment.
  task automatic send_item(input apf_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_edge(input int a, input int b);
    apf_pkg::in_item_t it;
    it.command = apf_pkg::CMD_ADD_EDGE;
    it.node_a = 6'(a);
    it.node_b = 6'(b);
    send_item(it);
  endtask

  // The endpoint fields mean nothing to a compute item, so they are random.
  task automatic send_compute();
    apf_pkg::in_item_t it;
    it.command = apf_pkg::CMD_COMPUTE;
    it.node_a = 6'($urandom);
    it.node_b = 6'($urandom);
    send_item(it);
  endtask

  // Waits until every expected result has come back, then lets the block
  // finish clearing its matrix before anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle; pready is always high.
  task automatic write_node_count(input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(4 * apf_pkg::REG_NODE_COUNT);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.nodes = value & 32'h7f;
  endtask

  // One random graph: mostly edges inside the active node range, some with
  // endpoints anywhere and a few self-loops, then the compute item.
  task automatic send_graph(input int nc);
    int span, edges, pick, a, b;
    span = (nc < 2) ? 2 : ((nc > 64) ? 64 : nc);
    edges = $urandom_range(0, (2 * span < 30) ? 2 * span : 30);
    for (int e = 0; e < edges; e++) begin
      pick = $urandom_range(0, 99);
      a = $urandom_range(0, span - 1);
      b = $urandom_range(0, span - 1);
      if (pick >= 95) begin
        b = a;
      end else if (pick >= 85) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end
      send_edge(a, b);
    end
    send_compute();
  endtask

  initial begin
    int counts [10];
    int sent;
    int nc;

    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_pct = 0;
    recv_pct = 0;
    hold_asked = 0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the reset node count of 64. A path 0-63-62 with a
    // duplicate edge and a self-loop makes node 63 the only cut vertex.
    send_edge(0, 63);
    send_edge(63, 0);
    send_edge(5, 5);
    send_edge(63, 62);
    send_compute();
    // An empty graph gives the single no-cut result.
    send_compute();
    // A star makes the root a cut vertex through its tree children count.
    send_edge(0, 1);
    send_edge(0, 2);
    send_edge(0, 3);
    send_compute();
    // A triangle with a tail: the tail joint is a cut vertex, the rest not.
    send_edge(10, 11);
    send_edge(11, 12);
    send_edge(12, 10);
    send_edge(12, 42);
    send_compute();
    drain();

    // Edges reaching past the node count are stored but do not count.
    write_node_count(3);
    send_edge(0, 1);
    send_edge(1, 2);
    send_edge(2, 40);
    send_edge(40, 63);
    send_compute();
    drain();

    // Random phases over several node counts, including zero, one and values
    // above the matrix size, with the idle mode rotating between phases.
    counts = '{5, 64, 1, 0, 127, 12, 3, 20, 65, 8};
    for (int ph = 0; ph < 10; ph++) begin
      nc = counts[ph];
      write_node_count(nc);
      case (ph % 4)
        0: begin
          send_pct = 0;
          recv_pct = 0;
        end
        1: begin
          send_pct = 53;
          recv_pct = 0;
        end
        2: begin
          send_pct = 0;
          recv_pct = 53;
        end
        default: begin
          send_pct = 9;
          recv_pct = 9;
        end
      endcase
      // In the first phase the receiver holds off for a long stretch while items
      // keep being offered, so a result waits in the block and input is stalled.
      if (ph == 0) hold_asked = hold_asked + 1;
      sent = items_sent;
      while (items_sent - sent < 40) begin
        send_graph(nc);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: articulation_point_finder_top.f
+incdir+rtl/core
rtl/core/apf_pkg.sv
rtl/core/apf_ctrl.sv
rtl/core/apf_datapath.sv
rtl/core/articulation_point_finder_top.sv
rtl/core/apf_checker.sv
verif/tb_articulation_point_finder_top.sv
